// ===== design/rte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the distance-vector route engine.
// No dependencies.
package rte_pkg;

  localparam int unsigned MAX_NODES = 16;

  localparam int unsigned NODE_W   = 5;
  localparam int unsigned COST_W   = 8;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned HOP_W    = 5;
  localparam int unsigned ROUNDS_W = 11;
  localparam int unsigned LIMIT_W  = 16;

  localparam logic [DIST_W-1:0] UNREACH = 16'hFFFF;
  localparam logic [DIST_W-1:0] SAT_SUM = 16'hFFFE;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RUN    = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic {
    REG_NODE_COUNT  = 1'b0,
    REG_COUNT_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [12:0] {
    S_CLR    = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_WR1    = 13'b0000000000100,
    S_WR2    = 13'b0000000001000,
    S_RD     = 13'b0000000010000,
    S_RDOUT  = 13'b0000000100000,
    S_COPY   = 13'b0000001000000,
    S_CDRAIN = 13'b0000010000000,
    S_PAIR   = 13'b0000100000000,
    S_SCAN   = 13'b0001000000000,
    S_DRAIN  = 13'b0010000000000,
    S_FIN    = 13'b0100000000000,
    S_REND   = 13'b1000000000000
  } state_e;

endpackage

// ===== design/rte_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/distance_vector_route_engine_unit.sv =====
`timescale 1ns / 1ps
// Top level of the distance-vector route engine: sequencer, tables, APB registers.
// Depends on rte_pkg and rte_ram.
// Add/remove writes both directions (S_WR1, S_WR2); a read goes through S_RD and S_RDOUT;
// a table op on bad nodes answers in the cycle after it is taken. A run repeats rounds of
// copy, pair scan and write-back; the single add/compare unit walks one neighbour per cycle.
// One request at a time: busy_o stays high until the done_o strobe.
// After reset a clearing pass over the link, distance and next-hop tables
// runs before the first request is taken; results cannot be stalled.
module distance_vector_route_engine_unit
  import rte_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          operation_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [COST_W-1:0]   cost_i,
  output logic                done_o,
  output logic [DIST_W-1:0]   distance_o,
  output logic [HOP_W-1:0]    next_hop_o,
  output logic                count_to_infinity_o,
  output logic [ROUNDS_W-1:0] rounds_o,
  output logic                round_limit_hit_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned AW = 2 * NW;
  localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);

  // configuration
  logic [NODE_W-1:0]  node_count_q;
  logic [LIMIT_W-1:0] count_limit_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (reg_idx_e'(paddr[2]) == REG_COUNT_LIMIT) ? 32'(count_limit_q)
                                                           : 32'(node_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NODE_W'(5);
      count_limit_q <= LIMIT_W'(100);
    end else if (cfg_wr) begin
      if (reg_idx_e'(paddr[2]) == REG_COUNT_LIMIT) begin
        count_limit_q <= pwdata[LIMIT_W-1:0];
      end else begin
        node_count_q <= pwdata[NODE_W-1:0];
      end
    end
  end

  // active node count, clamped
  logic [31:0]   act_n;
  logic [NW-1:0] last_idx;
  always_comb begin
    if (node_count_q == '0) act_n = 32'd1;
    else if (32'(node_count_q) > MAX_NODES) act_n = MAX_NODES;
    else act_n = 32'(node_count_q);
  end
  assign last_idx = NW'(act_n - 32'd1);

  // memories
  logic          link_we, dist_we, hop_we, prev_we;
  logic [AW-1:0] link_wa, dist_wa, hop_wa, prev_wa;
  logic [AW-1:0] link_ra, dist_ra, hop_ra, prev_ra;
  logic [COST_W-1:0] link_wd, link_rd;
  logic [DIST_W-1:0] dist_wd, dist_rd, prev_wd, prev_rd;
  logic [HOP_W-1:0]  hop_wd, hop_rd;

  rte_ram #(.Width(COST_W), .AddrW(AW)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_rd));
  rte_ram #(.Width(DIST_W), .AddrW(AW)) u_dist (
    .clk_i, .we_i(dist_we), .waddr_i(dist_wa), .wdata_i(dist_wd),
    .raddr_i(dist_ra), .rdata_o(dist_rd));
  rte_ram #(.Width(DIST_W), .AddrW(AW)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(prev_ra), .rdata_o(prev_rd));
  rte_ram #(.Width(HOP_W), .AddrW(AW)) u_hop (
    .clk_i, .we_i(hop_we), .waddr_i(hop_wa), .wdata_i(hop_wd),
    .raddr_i(hop_ra), .rdata_o(hop_rd));

  // sequencer state
  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [NW-1:0] s_q, s_d, d_q, d_d, k_q, k_d, sc_k_q, sc_k_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic [1:0]    op_q, op_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic          cp_v_q, cp_v_d, sc_v_q, sc_v_d, changed_q, changed_d;
  logic [AW-1:0] cp_addr_q, cp_addr_d;
  logic [DIST_W-1:0] best_q, best_d;
  logic [HOP_W-1:0]  bhop_q, bhop_d;
  logic [RW-1:0] round_q, round_d, last_rounds_q, last_rounds_d;
  logic          done_q, done_d, cti_q, cti_d, cap_q, cap_d;
  logic [DIST_W-1:0]   dist_out_q, dist_out_d;
  logic [HOP_W-1:0]    hop_out_q, hop_out_d;
  logic [ROUNDS_W-1:0] rnd_out_q, rnd_out_d;

  // shared add/compare unit
  logic [DIST_W:0]   sum_w;
  logic [DIST_W-1:0] sum_sat;
  logic              cand_ok;
  assign sum_w   = {{(DIST_W + 1 - COST_W){1'b0}}, link_rd} + {1'b0, prev_rd};
  assign sum_sat = (sum_w > {1'b0, SAT_SUM}) ? SAT_SUM : sum_w[DIST_W-1:0];
  assign cand_ok = (link_rd != '0) && (sc_k_q != s_q) && (prev_rd != UNREACH);

  logic          in_ok, del_link;
  logic [RW-1:0] rc;
  logic [NW-1:0] clr_row, clr_col;
  assign in_ok = (node_a_i != '0) && (32'(node_a_i) <= act_n) &&
                 (node_b_i != '0) && (32'(node_b_i) <= act_n);
  assign del_link = (op_e'(op_q) == OP_REMOVE) || (cost_q == '0);
  assign rc       = round_q + RW'(1);
  assign clr_row  = clr_q[AW-1:NW];
  assign clr_col  = clr_q[NW-1:0];

  always_comb begin
    state_d = state_q;   clr_d = clr_q;     s_d = s_q;       d_d = d_q;
    k_d = k_q;           sc_k_d = k_q;      a_d = a_q;       b_d = b_q;
    op_d = op_q;         cost_d = cost_q;   cp_v_d = 1'b0;   sc_v_d = 1'b0;
    cp_addr_d = {s_q, d_q};
    changed_d = changed_q; best_d = best_q; bhop_d = bhop_q;
    round_d = round_q;   last_rounds_d = last_rounds_q;
    done_d = 1'b0;       cti_d = cti_q;     cap_d = cap_q;
    dist_out_d = dist_out_q; hop_out_d = hop_out_q; rnd_out_d = rnd_out_q;

    link_we = 1'b0; link_wa = {a_q, b_q}; link_wd = '0;
    dist_we = 1'b0; dist_wa = {a_q, b_q}; dist_wd = UNREACH;
    hop_we  = 1'b0; hop_wa  = {a_q, b_q}; hop_wd  = '0;
    link_ra = {s_q, k_q};
    prev_ra = {k_q, d_q};
    dist_ra = {s_q, d_q};
    hop_ra  = {a_q, b_q};

    // copy pass writes the previous-round table in the cycle after its read
    prev_we = cp_v_q;
    prev_wa = cp_addr_q;
    prev_wd = dist_rd;

    if (sc_v_q && cand_ok && (sum_sat < best_q)) begin
      best_d = sum_sat;
      bhop_d = HOP_W'(32'(sc_k_q) + 32'd1);
    end

    unique case (state_q)
      S_CLR: begin
        link_we = 1'b1; link_wa = clr_q; link_wd = '0;
        dist_we = 1'b1; dist_wa = clr_q;
        dist_wd = (clr_row == clr_col) ? '0 : UNREACH;
        hop_we  = 1'b1; hop_wa  = clr_q;
        hop_wd  = (clr_row == clr_col) ? HOP_W'(32'(clr_row) + 32'd1) : '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          op_d   = operation_i;
          cost_d = cost_i;
          a_d    = NW'(32'(node_a_i) - 32'd1);
          b_d    = NW'(32'(node_b_i) - 32'd1);
          dist_out_d = '0; hop_out_d = '0; cti_d = 1'b0; cap_d = 1'b0;
          rnd_out_d  = ROUNDS_W'(last_rounds_q);
          unique case (op_e'(operation_i))
            OP_ADD, OP_REMOVE: begin
              if (in_ok && (node_a_i != node_b_i)) state_d = S_WR1;
              else done_d = 1'b1;
            end
            OP_RUN: begin
              s_d = '0; d_d = '0; round_d = '0; changed_d = 1'b0;
              state_d = S_COPY;
            end
            OP_READ: begin
              if (in_ok) begin
                state_d = S_RD;
              end else begin
                dist_out_d = UNREACH;
                done_d     = 1'b1;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_WR1, S_WR2: begin
        if (state_q == S_WR2) begin
          link_wa = {b_q, a_q}; dist_wa = {b_q, a_q}; hop_wa = {b_q, a_q};
        end
        link_we = 1'b1; dist_we = 1'b1; hop_we = 1'b1;
        link_wd = del_link ? '0 : cost_q;
        dist_wd = del_link ? UNREACH : DIST_W'(cost_q);
        hop_wd  = del_link ? '0 :
                  HOP_W'(32'((state_q == S_WR2) ? a_q : b_q) + 32'd1);
        if (state_q == S_WR2) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_WR2;
        end
      end
      S_RD: begin
        dist_ra = {a_q, b_q};
        state_d = S_RDOUT;
      end
      S_RDOUT: begin
        dist_out_d = dist_rd;
        hop_out_d  = hop_rd;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_COPY: begin
        cp_v_d = 1'b1;
        if (d_q == last_idx) begin
          d_d = '0;
          if (s_q == last_idx) begin
            s_d = '0;
            state_d = S_CDRAIN;
          end else begin
            s_d = s_q + NW'(1);
          end
        end else begin
          d_d = d_q + NW'(1);
        end
      end
      S_CDRAIN: begin
        changed_d = 1'b0;
        state_d   = S_PAIR;
      end
      S_PAIR, S_FIN: begin
        if (state_q == S_FIN) begin
          hop_we = 1'b1; hop_wa = {s_q, d_q}; hop_wd = bhop_q;
          dist_wa = {s_q, d_q}; dist_wd = best_q;
          if (dist_rd != best_q) begin
            dist_we   = 1'b1;
            changed_d = 1'b1;
          end
        end
        if ((state_q == S_FIN) && (best_q > count_limit_q) && (best_q != UNREACH)) begin
          // count to infinity: stop mid-round
          cti_d = 1'b1; last_rounds_d = rc; rnd_out_d = ROUNDS_W'(rc);
          done_d = 1'b1; state_d = S_IDLE;
        end else if ((state_q == S_PAIR) && (s_q != d_q)) begin
          best_d = UNREACH; bhop_d = '0; k_d = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_PAIR;
          if (d_q == last_idx) begin
            d_d = '0;
            if (s_q == last_idx) begin
              s_d = '0;
              state_d = S_REND;
            end else begin
              s_d = s_q + NW'(1);
            end
          end else begin
            d_d = d_q + NW'(1);
          end
        end
      end
      S_SCAN: begin
        sc_v_d = 1'b1;
        if (k_q == last_idx) state_d = S_DRAIN;
        else k_d = k_q + NW'(1);
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_REND: begin
        round_d = rc;
        if (!changed_q) begin
          last_rounds_d = rc; rnd_out_d = ROUNDS_W'(rc);
          done_d = 1'b1; state_d = S_IDLE;
        end else if (32'(rc) >= MAX_ROUNDS) begin
          last_rounds_d = rc; rnd_out_d = ROUNDS_W'(rc); cap_d = 1'b1;
          done_d = 1'b1; state_d = S_IDLE;
        end else begin
          s_d = '0; d_d = '0;
          state_d = S_COPY;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      clr_q         <= '0;
      cp_v_q        <= 1'b0;
      sc_v_q        <= 1'b0;
      done_q        <= 1'b0;
      last_rounds_q <= '0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      cp_v_q        <= cp_v_d;
      sc_v_q        <= sc_v_d;
      done_q        <= done_d;
      last_rounds_q <= last_rounds_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;  d_q <= d_d;  k_q <= k_d;  sc_k_q <= sc_k_d;
    a_q <= a_d;  b_q <= b_d;  op_q <= op_d; cost_q <= cost_d;
    cp_addr_q <= cp_addr_d;  changed_q <= changed_d;
    best_q <= best_d;  bhop_q <= bhop_d;  round_q <= round_d;
    cti_q <= cti_d;  cap_q <= cap_d;
    dist_out_q <= dist_out_d;  hop_out_q <= hop_out_d;  rnd_out_q <= rnd_out_d;
  end

  assign busy_o              = (state_q != S_IDLE);
  assign done_o              = done_q;
  assign distance_o          = dist_out_q;
  assign next_hop_o          = hop_out_q;
  assign count_to_infinity_o = cti_q;
  assign rounds_o            = rnd_out_q;
  assign round_limit_hit_o   = cap_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == OP_RUN)) |=> busy_o)
    else $error("run request did not raise busy");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(count_to_infinity_o && round_limit_hit_o))
    else $error("both stop flags set");
  a_rounds_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(last_rounds_q) <= MAX_ROUNDS) else $error("round count beyond cap");

endmodule

// ===== test/tb_distance_vector_route_engine_unit.sv =====
`timescale 1ns / 1ps
// Testbench for distance_vector_route_engine_unit: directed and random requests
// across several register settings, each result checked against an in-bench model.
// Depends on rte_pkg and the design sources.
module tb_distance_vector_route_engine_unit;
  import rte_pkg::*;

  localparam int unsigned NODES      = MAX_NODES;
  localparam int unsigned ROUND_CAP  = 1024;
  localparam int unsigned CYCLE_MAX  = 20000000;

  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [HOP_W-1:0]    hop;
    logic                cti;
    logic [ROUNDS_W-1:0] rounds;
    logic                cap;
  } route_result_t;

  class route_scoreboard;
    logic [COST_W-1:0] link_cost [NODES][NODES];
    logic [DIST_W-1:0] dist_tab  [NODES][NODES];
    logic [DIST_W-1:0] prev_tab  [NODES][NODES];
    logic [HOP_W-1:0]  hop_tab   [NODES][NODES];
    logic [ROUNDS_W-1:0] last_rounds;
    logic [NODE_W-1:0]  node_count;
    logic [LIMIT_W-1:0] count_limit;
    route_result_t pending[$];
    int unsigned fails;

    function new();
      fails = 0;
      node_count = 5;
      count_limit = 100;
      last_rounds = 0;
      for (int i = 0; i < NODES; i++) begin
        for (int j = 0; j < NODES; j++) begin
          link_cost[i][j] = 0;
          dist_tab[i][j] = (i == j) ? DIST_W'(0) : UNREACH;
          hop_tab[i][j] = (i == j) ? HOP_W'(i + 1) : HOP_W'(0);
        end
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      if (idx == REG_NODE_COUNT) node_count = val[NODE_W-1:0];
      else count_limit = val[LIMIT_W-1:0];
    endfunction

    function int unsigned active_nodes();
      if (node_count == 0) return 1;
      if (node_count > NODES) return NODES;
      return node_count;
    endfunction

    function void drop_link(int a, int b);
      link_cost[a][b] = 0;
      link_cost[b][a] = 0;
      dist_tab[a][b] = UNREACH;
      dist_tab[b][a] = UNREACH;
      hop_tab[a][b] = 0;
      hop_tab[b][a] = 0;
    endfunction

    // 0 settled, 1 changed, 2 finite distance beyond the limit
    function int relax_round(int n);
      bit changed;
      int unsigned best, hop, sum;
      changed = 0;
      prev_tab = dist_tab;
      for (int s = 0; s < n; s++) begin
        for (int d = 0; d < n; d++) begin
          if (s == d) continue;
          best = UNREACH;
          hop = 0;
          for (int k = 0; k < n; k++) begin
            if (link_cost[s][k] == 0 || k == s || prev_tab[k][d] == UNREACH) continue;
            sum = link_cost[s][k] + prev_tab[k][d];
            if (sum > SAT_SUM) sum = SAT_SUM;
            if (sum < best) begin
              best = sum;
              hop = k + 1;
            end
          end
          hop_tab[s][d] = HOP_W'(hop);
          if (dist_tab[s][d] != best) begin
            dist_tab[s][d] = DIST_W'(best);
            changed = 1;
          end
          if (best > count_limit && best < UNREACH) return 2;
        end
      end
      return changed ? 1 : 0;
    endfunction

    function void note_request(op_e op, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
                               logic [COST_W-1:0] cost);
      route_result_t r;
      int n, a, b, st, cnt;
      bit ok;
      n = active_nodes();
      ok = na >= 1 && na <= n && nb >= 1 && nb <= n;
      a = ok ? na - 1 : 0;
      b = ok ? nb - 1 : 0;
      r = '0;
      case (op)
        OP_ADD: begin
          if (ok && a != b) begin
            if (cost == 0) drop_link(a, b);
            else begin
              link_cost[a][b] = cost;
              link_cost[b][a] = cost;
              dist_tab[a][b] = DIST_W'(cost);
              dist_tab[b][a] = DIST_W'(cost);
              hop_tab[a][b] = HOP_W'(b + 1);
              hop_tab[b][a] = HOP_W'(a + 1);
            end
          end
        end
        OP_REMOVE: if (ok && a != b) drop_link(a, b);
        OP_RUN: begin
          cnt = 0;
          forever begin
            st = relax_round(n);
            cnt++;
            if (st == 2) begin
              r.cti = 1'b1;
              break;
            end
            if (st == 0) break;
            if (cnt >= ROUND_CAP) begin
              r.cap = 1'b1;
              break;
            end
          end
          last_rounds = ROUNDS_W'(cnt);
        end
        default: begin
          r.distance = ok ? dist_tab[a][b] : UNREACH;
          r.hop = ok ? hop_tab[a][b] : HOP_W'(0);
        end
      endcase
      r.rounds = last_rounds;
      pending.insert(pending.size(), r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_result(route_result_t got);
      route_result_t exp;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.distance !== exp.distance)
        report($sformatf("distance %0d, want %0d", got.distance, exp.distance));
      if (got.hop !== exp.hop) report($sformatf("next hop %0d, want %0d", got.hop, exp.hop));
      if (got.cti !== exp.cti)
        report($sformatf("count to infinity %0b, want %0b", got.cti, exp.cti));
      if (got.rounds !== exp.rounds)
        report($sformatf("rounds %0d, want %0d", got.rounds, exp.rounds));
      if (got.cap !== exp.cap) report($sformatf("round cap %0b, want %0b", got.cap, exp.cap));
    endtask
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] operation_i = 2'd0;
  logic [NODE_W-1:0] node_a_i = '0;
  logic [NODE_W-1:0] node_b_i = '0;
  logic [COST_W-1:0] cost_i = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy_o, done_o, count_to_infinity_o, round_limit_hit_o, pready;
  logic [DIST_W-1:0] distance_o;
  logic [HOP_W-1:0] next_hop_o;
  logic [ROUNDS_W-1:0] rounds_o;
  logic [31:0] prdata;

  route_scoreboard routes = new();
  int unsigned cycles = 0;
  int unsigned gap_pct = 0;

  distance_vector_route_engine_unit #(.MAX_ROUNDS(ROUND_CAP)) i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .node_a_i, .node_b_i, .cost_i,
    .done_o, .distance_o, .next_hop_o, .count_to_infinity_o, .rounds_o, .round_limit_hit_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_MAX) begin
      $display("tb_distance_vector_route_engine_unit failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && done_o)
      routes.check_result({distance_o, next_hop_o, count_to_infinity_o, rounds_o,
                           round_limit_hit_o});

  // returns on the edge that takes the request, or after a random idle gap behind it
  task automatic send(op_e op, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
                      logic [COST_W-1:0] cost);
    start_i <= 1'b1;
    operation_i <= op;
    node_a_i <= na;
    node_b_i <= nb;
    cost_i <= cost;
    do @(posedge clk_i); while (busy_o);
    routes.note_request(op, na, nb, cost);
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (routes.pending.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    routes.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned nc, int unsigned lim, int unsigned items,
                              int unsigned min_cost, int unsigned pct);
    int unsigned n, pick;
    logic [NODE_W-1:0] na, nb;
    logic [COST_W-1:0] cost;
    drain();
    write_reg(REG_NODE_COUNT, nc);
    write_reg(REG_COUNT_LIMIT, lim);
    @(posedge clk_i);
    gap_pct = pct;
    n = routes.active_nodes();
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        na = NODE_W'($urandom);
        nb = NODE_W'($urandom);
      end else begin
        na = NODE_W'($urandom_range(1, n));
        nb = NODE_W'($urandom_range(1, n));
      end
      cost = $urandom_range(99) < 3 ? COST_W'(0) : COST_W'($urandom_range(min_cost, 255));
      if (pick < 35) send(OP_ADD, na, nb, cost);
      else if (pick < 45) send(OP_REMOVE, na, nb, COST_W'($urandom));
      else if (pick < 60)
        send(OP_RUN, NODE_W'($urandom), NODE_W'($urandom), COST_W'($urandom));
      else send(OP_READ, na, nb, COST_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: five nodes, limit 100
    send(OP_READ, 0, 1, 0);
    send(OP_READ, 1, 6, 0);
    send(OP_READ, 3, 3, 0);
    send(OP_ADD, 1, 2, 255);
    send(OP_ADD, 2, 3, 1);
    send(OP_ADD, 4, 4, 9);
    send(OP_ADD, 0, 2, 7);
    send(OP_ADD, 5, 31, 7);
    send(OP_ADD, 3, 4, 2);
    send(OP_ADD, 1, 4, 2);
    send(OP_RUN, 31, 31, 255);
    send(OP_READ, 1, 3, 0);
    send(OP_READ, 5, 1, 0);
    send(OP_ADD, 1, 4, 0);
    send(OP_REMOVE, 2, 2, 0);
    send(OP_REMOVE, 3, 4, 0);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 2, 4, 0);
    drain();
    // sender holds back until every result is in
    send(OP_ADD, 4, 5, 3);
    send(OP_RUN, 1, 1, 1);
    send(OP_READ, 4, 5, 0);

    random_phase(3, 65534, 15, 1, 0);
    random_phase(16, 100, 20, 40, 56);
    random_phase(0, 1, 10, 1, 31);
    random_phase(4, 1, 20, 1, 0);
    random_phase(31, 200, 10, 100, 56);
    random_phase(2, 65534, 10, 1, 31);
    random_phase(8, 1000, 20, 20, 56);
    random_phase(6, 65534, 20, 1, 0);

    drain();
    repeat (20) @(posedge clk_i);
    if (routes.fails == 0) $display("tb_distance_vector_route_engine_unit passed");
    else $display("tb_distance_vector_route_engine_unit failed");
    $finish;
  end

endmodule
